// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, constants, register codes and cell data types.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int ROOT_W    = 16;
   localparam int RAD_W     = 32;
   localparam int REM_W     = 18;
   localparam int ANG_W     = 33;
   localparam int Q_W       = 28;
   localparam int R_W       = 54;
   localparam int N_W       = 58;
   localparam int D_W       = 37;
   localparam int QT_W      = 18;
   localparam int DIV_STEPS = 18;
   localparam int SQRT_STEPS = 16;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_AZIMUTH   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_AZIMUTH   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ELEVATION = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ELEVATION = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_OFFSET = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_LENGTH  = 4'd7;

   localparam logic [ANG_W-1:0] TWO_PI_Q30      = 33'd6746518852;
   localparam logic [ANG_W-1:0] PI_Q30          = 33'd3373259426;
   localparam logic [ANG_W-1:0] HALF_PI_Q30     = 33'd1686629713;
   localparam logic [ANG_W-1:0] CORDIC_GAIN_Q30 = 33'd652032874;

   localparam int ATAN_N = 24;
   localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] cx;
      logic signed [ANG_W-1:0] cy;
      logic signed [ANG_W-1:0] ang;
      logic                    neg;
   } cordic_type;

   typedef struct packed {
      logic [N_W-1:0]  rem_x;
      logic [N_W-1:0]  rem_y;
      logic [D_W-1:0]  den;
      logic [QT_W-1:0] qt_x;
      logic [QT_W-1:0] qt_y;
      logic            neg_x;
      logic            neg_y;
      logic            behind;
      logic            xq_neg;
      logic            yq_neg;
   } div_type;

endpackage

// ----- design/spp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// spp_sqrt_cell
// One digit of the integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module spp_sqrt_cell (
   input  logic              clock,
   input  logic              advance,
   input  spp_pkg::sqrt_type in_d,
   output spp_pkg::sqrt_type out_q
);

   logic [spp_pkg::REM_W+1:0] rem_sh;
   logic [spp_pkg::REM_W+1:0] trial;
   logic [spp_pkg::REM_W+1:0] diff;
   spp_pkg::sqrt_type         out_in;
   spp_pkg::sqrt_type         out_ff;

   always_comb begin
      rem_sh     = {in_d.rem, in_d.rad[spp_pkg::RAD_W-1 -: 2]};
      trial      = (spp_pkg::REM_W+2)'({in_d.root, 2'b01});
      diff       = rem_sh - trial;
      out_in.rad = in_d.rad << 2;
      if (rem_sh >= trial) begin
         out_in.rem  = diff[spp_pkg::REM_W-1:0];
         out_in.root = {in_d.root[spp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         out_in.rem  = rem_sh[spp_pkg::REM_W-1:0];
         out_in.root = {in_d.root[spp_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_q = out_ff;

endmodule

// ----- design/spp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// spp_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module spp_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                advance,
   input  spp_pkg::cordic_type in_d,
   output spp_pkg::cordic_type out_q
);

   logic signed [spp_pkg::ANG_W-1:0] cx;
   logic signed [spp_pkg::ANG_W-1:0] cy;
   logic signed [spp_pkg::ANG_W-1:0] shx;
   logic signed [spp_pkg::ANG_W-1:0] shy;
   logic signed [spp_pkg::ANG_W-1:0] atan;
   spp_pkg::cordic_type              out_in;
   spp_pkg::cordic_type              out_ff;

   always_comb begin
      cx   = in_d.cx;
      cy   = in_d.cy;
      shx  = cx >>> SHIFT;
      shy  = cy >>> SHIFT;
      atan = signed'(spp_pkg::ANG_W'(spp_pkg::ATAN_TAB[SHIFT]));
      out_in.neg = in_d.neg;
      // rotate toward zero residual angle
      if (!in_d.ang[spp_pkg::ANG_W-1]) begin
         out_in.cx  = cx - shy;
         out_in.cy  = cy + shx;
         out_in.ang = in_d.ang - atan;
      end else begin
         out_in.cx  = cx + shy;
         out_in.cy  = cy - shx;
         out_in.ang = in_d.ang + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_q = out_ff;

endmodule

// ----- design/spp_div_cell.sv -----
// ----------------------------------------------------------------------------
// spp_div_cell
// One restoring division step for both screen axes against a shared divisor.
// ----------------------------------------------------------------------------
module spp_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             advance,
   input  spp_pkg::div_type in_d,
   output spp_pkg::div_type out_q
);

   logic [spp_pkg::N_W-1:0] dsh;
   logic                    take_x;
   logic                    take_y;
   spp_pkg::div_type        out_in;
   spp_pkg::div_type        out_ff;

   always_comb begin
      dsh    = spp_pkg::N_W'(in_d.den) << SHIFT;
      take_x = in_d.rem_x >= dsh;
      take_y = in_d.rem_y >= dsh;
      out_in = in_d;
      out_in.rem_x = take_x ? in_d.rem_x - dsh : in_d.rem_x;
      out_in.rem_y = take_y ? in_d.rem_y - dsh : in_d.rem_y;
      out_in.qt_x  = {in_d.qt_x[spp_pkg::QT_W-2:0], take_x};
      out_in.qt_y  = {in_d.qt_y[spp_pkg::QT_W-2:0], take_y};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_q = out_ff;

endmodule

// ----- design/surface_point_projector_core.sv -----
// ----------------------------------------------------------------------------
// surface_point_projector_core
// Surface height by square root and CORDIC cosine, view rotation, perspective
// divide and pixel mapping, as one stalling pipeline of cell chains.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Payload
//  req      in   req_valid/req_ready    grid_x, grid_y
//  rsp      out  rsp_valid/rsp_ready    screen_x, screen_y, behind_camera
//  csr      in   csr_we                 csr_index, csr_wdata
//
//  One request enters per cycle unless the pipeline holds; each passes through
//  the root, CORDIC and divider cell chains.
//  The whole pipeline holds while a result waits on rsp_ready.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module surface_point_projector_core #(
   parameter int COORD_FRAC_BITS = 10,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [15:0]                    req_grid_x,
   input  logic signed [15:0]                    req_grid_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [15:0]                    rsp_screen_x,
   output logic signed [15:0]                    rsp_screen_y,
   output logic                                  rsp_behind_camera,
   input  logic                                  csr_we,
   input  logic [spp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [spp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int F  = COORD_FRAC_BITS;
   localparam int NC = (CORDIC_STAGES < spp_pkg::ATAN_N) ? CORDIC_STAGES : spp_pkg::ATAN_N;
   localparam int A_W = spp_pkg::ROOT_W + 30 - F;
   localparam int MOD_STEPS = (A_W > 32) ? A_W - 32 : 1;
   localparam int M_W = A_W + 1;
   localparam int H_W = F + 4;
   localparam int DL  = 19 + MOD_STEPS + NC;
   localparam int LAT = 45 + MOD_STEPS + NC;
   localparam int ST_SQRT   = 17;
   localparam int ST_FOLD   = 19 + MOD_STEPS;
   localparam int ST_DIV_IN = 25 + MOD_STEPS + NC;
   localparam int Q_W = spp_pkg::Q_W;
   localparam int R_W = spp_pkg::R_W;
   localparam int N_W = spp_pkg::N_W;
   localparam int D_W = spp_pkg::D_W;

   typedef struct packed {
      logic signed [32:0] m;
      logic signed [32:0] xs;
   } rot_type;

   // configuration
   logic [11:0]        scr_w_ff;
   logic [11:0]        scr_h_ff;
   logic signed [15:0] sin_az_ff;
   logic signed [15:0] cos_az_ff;
   logic signed [15:0] sin_el_ff;
   logic signed [15:0] cos_el_ff;
   logic [15:0]        cam_off_ff;
   logic [15:0]        focal_ff;
   logic [27:0]        fh_ff;

   logic             advance;
   logic [LAT-1:0]   vld_ff;

   logic [30:0]        sqx_ff;
   logic [30:0]        sqy_ff;
   logic signed [31:0] p_xca_ff;
   logic signed [31:0] p_ysa_ff;
   logic signed [31:0] p_xsa_ff;
   logic signed [31:0] p_yca_ff;
   logic [31:0]        r2_ff;
   logic signed [32:0] m_ff;
   logic signed [32:0] xs_ff;
   rot_type            dly_ff [DL];
   rot_type            rot_tail;

   spp_pkg::sqrt_type   sqrt_bus [spp_pkg::SQRT_STEPS+1];
   logic [A_W-1:0]      ang_start;
   logic [M_W-1:0]      mod_ff [MOD_STEPS];
   logic [spp_pkg::ANG_W-1:0] ang_red;
   logic [spp_pkg::ANG_W-1:0] f1_ff;
   spp_pkg::cordic_type cdc_init_ff;
   spp_pkg::cordic_type cdc_bus [NC+1];

   logic signed [32:0]      cval;
   logic signed [H_W-1:0]   h_ff;
   logic signed [48:0]      ym_ff;
   logic signed [48:0]      zm_ff;
   logic signed [H_W+15:0]  hs_ff;
   logic signed [H_W+15:0]  hc_ff;
   logic signed [Q_W-1:0]   xq1_ff;
   logic signed [R_W-1:0]   y_a, y_b, z_a, z_b, z_c, y_sum, z_sum;
   logic signed [Q_W-1:0]   xq2_ff;
   logic signed [Q_W-1:0]   yq_ff;
   logic signed [Q_W-1:0]   zq_ff;

   logic signed [28:0]      fh_s;
   logic signed [12:0]      w_s;
   logic signed [12:0]      h_s;
   logic signed [56:0]      fx_ff;
   logic signed [56:0]      fy_ff;
   logic signed [Q_W+12:0]  wz_ff;
   logic signed [Q_W+12:0]  hz_ff;
   logic signed [Q_W-1:0]   zq3_ff;
   logic                    xneg3_ff;
   logic                    yneg3_ff;

   logic signed [N_W-1:0]   nx_ff;
   logic signed [N_W-1:0]   ny_ff;
   logic [D_W-1:0]          den_ff;
   logic                    behind_ff;
   logic                    xneg4_ff;
   logic                    yneg4_ff;

   spp_pkg::div_type        div_in_ff;
   spp_pkg::div_type        div_bus [spp_pkg::DIV_STEPS+1];
   spp_pkg::div_type        div_out;

   logic signed [15:0]      sx_in;
   logic signed [15:0]      sy_in;
   logic signed [15:0]      sx_ff;
   logic signed [15:0]      sy_ff;
   logic                    bh_ff;

   function automatic logic signed [15:0] sat_q(input logic neg,
                                                input logic [spp_pkg::QT_W-1:0] q);
      logic signed [15:0] r;
      if (neg) begin
         r = (q > spp_pkg::QT_W'(32768)) ? 16'sh8000 : -signed'(q[15:0]);
      end else begin
         r = (q > spp_pkg::QT_W'(32767)) ? 16'sh7FFF : signed'(q[15:0]);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff   <= 12'd800;
         scr_h_ff   <= 12'd600;
         sin_az_ff  <= 16'sd15710;
         cos_az_ff  <= 16'sd28756;
         sin_el_ff  <= 16'sd18502;
         cos_el_ff  <= 16'sd27044;
         cam_off_ff <= 16'd15360;
         focal_ff   <= 16'd2560;
      end else if (csr_we) begin
         case (csr_index)
            spp_pkg::CSR_SCREEN_WIDTH: begin
               scr_w_ff <= csr_wdata[11:0];
            end
            spp_pkg::CSR_SCREEN_HEIGHT: begin
               scr_h_ff <= csr_wdata[11:0];
            end
            spp_pkg::CSR_SIN_AZIMUTH: begin
               sin_az_ff <= signed'(csr_wdata);
            end
            spp_pkg::CSR_COS_AZIMUTH: begin
               cos_az_ff <= signed'(csr_wdata);
            end
            spp_pkg::CSR_SIN_ELEVATION: begin
               sin_el_ff <= signed'(csr_wdata);
            end
            spp_pkg::CSR_COS_ELEVATION: begin
               cos_el_ff <= signed'(csr_wdata);
            end
            spp_pkg::CSR_CAMERA_OFFSET: begin
               cam_off_ff <= csr_wdata;
            end
            spp_pkg::CSR_FOCAL_LENGTH: begin
               focal_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      fh_ff <= 28'(scr_h_ff) * 28'(focal_ff);
   end

   // --------------------------------------------------------------- control
   assign advance   = !(vld_ff[LAT-1] && !rsp_ready);
   assign req_ready = advance;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ------------------------------------------------------ products and sums
   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff   <= 31'(32'(req_grid_x) * 32'(req_grid_x));
         sqy_ff   <= 31'(32'(req_grid_y) * 32'(req_grid_y));
         p_xca_ff <= req_grid_x * cos_az_ff;
         p_ysa_ff <= req_grid_y * sin_az_ff;
         p_xsa_ff <= req_grid_x * sin_az_ff;
         p_yca_ff <= req_grid_y * cos_az_ff;
         r2_ff    <= 32'(sqx_ff) + 32'(sqy_ff);
         m_ff     <= 33'(p_xca_ff) - 33'(p_ysa_ff);
         xs_ff    <= 33'(p_xsa_ff) + 33'(p_yca_ff);
      end
   end

   // carry the rotation terms alongside the height path
   always_ff @(posedge clock) begin
      if (advance) begin
         dly_ff[0] <= '{m: m_ff, xs: xs_ff};
         for (int i = 1; i < DL; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign rot_tail = dly_ff[DL-1];

   // ---------------------------------------------------------- square root
   assign sqrt_bus[0] = '{rad: r2_ff, rem: '0, root: '0};

   for (genvar i = 0; i < spp_pkg::SQRT_STEPS; i++) begin : g_sqrt
      spp_sqrt_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .in_d    (sqrt_bus[i]),
         .out_q   (sqrt_bus[i+1])
      );
   end

   // ------------------------------------------------- angle reduction, 2 pi
   assign ang_start = A_W'(sqrt_bus[spp_pkg::SQRT_STEPS].root) << (30 - F);

   for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
      localparam int S = MOD_STEPS - 1 - j;
      logic [M_W-1:0] src;
      logic [M_W-1:0] lim;
      if (j == 0) begin : g_first
         assign src = M_W'(ang_start);
      end else begin : g_next
         assign src = mod_ff[j-1];
      end
      assign lim = M_W'(spp_pkg::TWO_PI_Q30) << S;
      always_ff @(posedge clock) begin
         if (advance) begin
            mod_ff[j] <= (src >= lim) ? src - lim : src;
         end
      end
   end

   assign ang_red = mod_ff[MOD_STEPS-1][spp_pkg::ANG_W-1:0];

   // fold into the first quadrant
   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff <= (ang_red > spp_pkg::PI_Q30) ? spp_pkg::TWO_PI_Q30 - ang_red : ang_red;
         cdc_init_ff.cx <= signed'(spp_pkg::CORDIC_GAIN_Q30);
         cdc_init_ff.cy <= '0;
         if (f1_ff > spp_pkg::HALF_PI_Q30) begin
            cdc_init_ff.ang <= signed'(spp_pkg::PI_Q30 - f1_ff);
            cdc_init_ff.neg <= 1'b1;
         end else begin
            cdc_init_ff.ang <= signed'(f1_ff);
            cdc_init_ff.neg <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- cosine
   assign cdc_bus[0] = cdc_init_ff;

   for (genvar i = 0; i < NC; i++) begin : g_cordic
      spp_cordic_cell #(.SHIFT(i)) u_cell (
         .clock   (clock),
         .advance (advance),
         .in_d    (cdc_bus[i]),
         .out_q   (cdc_bus[i+1])
      );
   end

   assign cval = cdc_bus[NC].neg ? -cdc_bus[NC].cx : cdc_bus[NC].cx;

   // -------------------------------------------------------------- rotation
   always_comb begin
      y_a   = R_W'(ym_ff);
      y_b   = R_W'(hs_ff) <<< 15;
      z_a   = R_W'(zm_ff);
      z_b   = R_W'(hc_ff) <<< 15;
      z_c   = signed'(R_W'(cam_off_ff) << (F + 22));
      y_sum = y_a + y_b;
      z_sum = z_a - z_b + z_c;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_ff   <= H_W'(cval >>> (30 - F));
         ym_ff  <= rot_tail.m * cos_el_ff;
         zm_ff  <= rot_tail.m * sin_el_ff;
         hs_ff  <= h_ff * sin_el_ff;
         hc_ff  <= h_ff * cos_el_ff;
         xq1_ff <= Q_W'(rot_tail.xs >>> (F - 1));
         xq2_ff <= xq1_ff;
         yq_ff  <= Q_W'(y_sum >>> (F + 14));
         zq_ff  <= Q_W'(z_sum >>> (F + 14));
      end
   end

   // ------------------------------------------------------------ projection
   assign fh_s = signed'({1'b0, fh_ff});
   assign w_s  = signed'({1'b0, scr_w_ff});
   assign h_s  = signed'({1'b0, scr_h_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff    <= fh_s * xq2_ff;
         fy_ff    <= fh_s * yq_ff;
         wz_ff    <= w_s * zq_ff;
         hz_ff    <= h_s * zq_ff;
         zq3_ff   <= zq_ff;
         xneg3_ff <= xq2_ff[Q_W-1];
         yneg3_ff <= yq_ff[Q_W-1];

         nx_ff     <= N_W'(fx_ff) + (N_W'(wz_ff) <<< 8);
         ny_ff     <= (N_W'(hz_ff) <<< 8) - N_W'(fy_ff);
         den_ff    <= D_W'(zq3_ff) << 9;
         behind_ff <= zq3_ff[Q_W-1] || (zq3_ff == '0);
         xneg4_ff  <= xneg3_ff;
         yneg4_ff  <= yneg3_ff;

         div_in_ff.rem_x  <= nx_ff[N_W-1] ? N_W'(-nx_ff) : N_W'(nx_ff);
         div_in_ff.rem_y  <= ny_ff[N_W-1] ? N_W'(-ny_ff) : N_W'(ny_ff);
         div_in_ff.den    <= den_ff;
         div_in_ff.qt_x   <= '0;
         div_in_ff.qt_y   <= '0;
         div_in_ff.neg_x  <= nx_ff[N_W-1];
         div_in_ff.neg_y  <= ny_ff[N_W-1];
         div_in_ff.behind <= behind_ff;
         div_in_ff.xq_neg <= xneg4_ff;
         div_in_ff.yq_neg <= yneg4_ff;
      end
   end

   // -------------------------------------------------------------- divider
   assign div_bus[0] = div_in_ff;

   for (genvar i = 0; i < spp_pkg::DIV_STEPS; i++) begin : g_div
      spp_div_cell #(.SHIFT(spp_pkg::DIV_STEPS - 1 - i)) u_cell (
         .clock   (clock),
         .advance (advance),
         .in_d    (div_bus[i]),
         .out_q   (div_bus[i+1])
      );
   end

   assign div_out = div_bus[spp_pkg::DIV_STEPS];

   always_comb begin
      if (div_out.behind) begin
         sx_in = div_out.xq_neg ? 16'sh8000 : 16'sh7FFF;
         sy_in = div_out.yq_neg ? 16'sh7FFF : 16'sh8000;
      end else begin
         sx_in = sat_q(div_out.neg_x, div_out.qt_x);
         sy_in = sat_q(div_out.neg_y, div_out.qt_y);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         bh_ff <= div_out.behind;
      end
   end

   assign rsp_screen_x      = sx_ff;
   assign rsp_screen_y      = sy_ff;
   assign rsp_behind_camera = bh_ff;

   // ----------------------------------------------------------- assertions
   `ASSERT_IMPL(a_sqrt_rem, clock, reset, vld_ff[ST_SQRT], 19'(sqrt_bus[spp_pkg::SQRT_STEPS].rem) <= {2'b00, sqrt_bus[spp_pkg::SQRT_STEPS].root, 1'b0}, "square root remainder out of range")
   `ASSERT_IMPL(a_fold_range, clock, reset, vld_ff[ST_FOLD], !cdc_init_ff.ang[spp_pkg::ANG_W-1] && (unsigned'(cdc_init_ff.ang) <= spp_pkg::HALF_PI_Q30), "folded angle outside first quadrant")
   `ASSERT_IMPL(a_den_nonzero, clock, reset, vld_ff[ST_DIV_IN] && !div_in_ff.behind, div_in_ff.den != '0, "zero divisor for a point in front")
   `ASSERT_IMPL(a_behind_sat, clock, reset, rsp_valid && rsp_behind_camera, (rsp_screen_x == 16'sh7FFF || rsp_screen_x == 16'sh8000) && (rsp_screen_y == 16'sh7FFF || rsp_screen_y == 16'sh8000), "behind-camera result not saturated")
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, $stable(vld_ff), "pipeline moved during output stall")

endmodule
